/* rtl/eto_pkg.sv */
package eto_pkg;

    localparam int NUMBER_BITS = 12;
    // orbit position k never exceeds 2n, so it needs one bit more than n
    localparam int WALK_BITS   = NUMBER_BITS + 1;

    typedef logic [NUMBER_BITS-1:0] number_t;
    typedef logic [WALK_BITS-1:0]   walk_t;

endpackage

/* rtl/eto_number_if.sv */
interface eto_number_if
    import eto_pkg::*;
();
    logic    valid;
    logic    ready;
    number_t number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

/* rtl/eto_totient_if.sv */
interface eto_totient_if
    import eto_pkg::*;
();
    logic    valid;
    logic    ready;
    number_t totient;

    modport source (output valid, output totient, input ready);
    modport sink   (input valid, input totient, output ready);
endinterface

/* rtl/euler_totient_by_orbits.sv */
// Euler's totient by orbit counting. Each number n on the input channel gives
// one totient on the output channel. For every d in 1..n the block walks k from
// 1+d back to 1, subtracting n on a wrap and adding d otherwise, and counts d
// when the walk wraps exactly d times. One shared adder takes one walk step a
// cycle; each d is seeded in S_LOAD and walked in S_WALK, and n = 0 goes
// straight to S_DONE. The block takes one item at a time; it accepts the next
// number while the previous totient still waits on the output register.
module euler_totient_by_orbits
    import eto_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    eto_number_if.sink          num,
    eto_totient_if.source       tot
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    number_t    n_reg, n_next;
    number_t    d_reg, d_next;
    number_t    wraps_reg, wraps_next;
    number_t    count_reg, count_next;
    walk_t      k_reg, k_next;
    logic       out_valid_reg, out_valid_next;
    number_t    out_data_reg, out_data_next;

    walk_t      add_a, add_b, add_sum;
    logic       k_over;
    logic       out_free;

    assign num.ready   = (state_reg == S_IDLE);
    assign tot.valid   = out_valid_reg;
    assign tot.totient = out_data_reg;

    assign out_free = !out_valid_reg || tot.ready;
    assign k_over   = (k_reg > {1'b0, n_reg});

    // shared adder: seeds k = 1 + d, then steps k by +d or -n
    always_comb
    begin
        if (state_reg == S_LOAD)
        begin
            add_a = walk_t'(1);
            add_b = {1'b0, d_reg};
        end
        else
        begin
            add_a = k_reg;
            add_b = k_over ? (~{1'b0, n_reg} + walk_t'(1)) : {1'b0, d_reg};
        end
        add_sum = add_a + add_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        wraps_next     = wraps_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && tot.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (num.valid)
                begin
                    n_next     = num.number;
                    d_next     = number_t'(1);
                    count_next = '0;
                    state_next = (num.number == '0) ? S_DONE : S_LOAD;
                end
            end
            S_LOAD:
            begin
                k_next     = add_sum;
                wraps_next = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (k_reg == walk_t'(1))
                begin
                    if (wraps_reg == d_reg)
                    begin
                        count_next = count_reg + number_t'(1);
                    end
                    if (d_reg == n_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        d_next     = d_reg + number_t'(1);
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    k_next = add_sum;
                    if (k_over)
                    begin
                        wraps_next = wraps_reg + number_t'(1);
                    end
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        d_reg        <= d_next;
        wraps_reg    <= wraps_next;
        count_reg    <= count_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

endmodule

/* rtl/eto_checker.sv */
module eto_checker
    import eto_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    num_valid,
    input logic    num_ready,
    input number_t number,
    input logic    tot_valid,
    input logic    tot_ready,
    input number_t totient
);

    // a stalled result holds its value
    a_tot_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tot_valid && !tot_ready |=> tot_valid && $stable(totient))
        else $error("totient changed or dropped while stalled");

    // one number at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready |=> !num_ready)
        else $error("input ready right after accepting a number");

    // a fresh result only comes out of a busy block, never straight from idle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tot_valid) |-> $past(!num_ready))
        else $error("result appeared while idle");

    // a zero number is still a full transaction: go busy to emit its result
    a_zero_busy: assert property (@(posedge clk) disable iff (!rst_n)
        num_valid && num_ready && number == '0 |=> !num_ready)
        else $error("zero input not handled as a transaction");

endmodule

bind euler_totient_by_orbits eto_checker u_eto_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_valid (num.valid),
    .num_ready (num.ready),
    .number    (num.number),
    .tot_valid (tot.valid),
    .tot_ready (tot.ready),
    .totient   (tot.totient)
);

/* dv/totient_checker.sv */
module totient_checker
    import eto_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    eto_number_if  num,
    eto_totient_if tot,
    output int     errors,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        number_t number;
        number_t totient;
    } totient_expect_t;

    totient_expect_t expected_totients[$];
    int              error_count = 0;

    // count d in 1..n with gcd(d, n) == 1
    function automatic number_t count_coprimes(input number_t n);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        int unsigned hits;
        hits = 0;
        for (int unsigned d = 1; d <= n; d++)
        begin
            a = d;
            b = n;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            if (a == 1)
                hits++;
        end
        return number_t'(hits);
    endfunction

    always @(posedge clk)
    begin
        totient_expect_t head;
        if (rst_n)
        begin
            // check the result before queuing a new number: it cannot belong to it
            if (tot.valid && tot.ready)
            begin
                if (expected_totients.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected totient transaction: expected none, got %0d",
                             $time, tot.totient);
                end
                else
                begin
                    head = expected_totients.pop_front();
                    if (tot.totient !== head.totient)
                    begin
                        error_count++;
                        $display("%0t: totient of %0d: expected %0d, got %0d",
                                 $time, head.number, head.totient, tot.totient);
                    end
                end
            end
            if (num.valid && num.ready)
            begin
                head.number  = num.number;
                head.totient = count_coprimes(num.number);
                expected_totients.push_back(head);
            end
        end
        errors  <= error_count;
        pending <= expected_totients.size();
    end

endmodule

/* dv/tb_euler_totient_by_orbits.sv */
module tb_euler_totient_by_orbits
    import eto_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct;
    int dst_idle_pct;
    bit stall_request;
    int errors;
    int pending;

    eto_number_if  num_ch ();
    eto_totient_if tot_ch ();

    euler_totient_by_orbits dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_ch),
        .tot   (tot_ch)
    );

    totient_checker checker_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .num     (num_ch),
        .tot     (tot_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly small n, since larger n take far longer to walk
    function automatic number_t pick_number(input int idx);
        int r;
        r = $urandom_range(99);
        if (idx % 40 == 17)
            return number_t'($urandom_range(1023, 256));
        else if (r < 70)
            return number_t'($urandom_range(63, 0));
        else
            return number_t'($urandom_range(255, 64));
    endfunction

    task automatic send_number(input number_t value);
        while ($urandom_range(99) < src_idle_pct)
        begin
            num_ch.valid <= 1'b0;
            @(posedge clk);
        end
        num_ch.valid  <= 1'b1;
        num_ch.number <= value;
        do
            @(posedge clk);
        while (!num_ch.ready);
    endtask

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin
        int  stall_left;
        bit  stall_done;
        stall_left   = 0;
        stall_done   = 0;
        tot_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                tot_ch.ready <= 1'b0;
            end
            else if (stall_request && !stall_done)
            begin
                stall_done   = 1;
                stall_left   = 20000;
                tot_ch.ready <= 1'b0;
            end
            else
                tot_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    initial
    begin
        number_t corner_numbers[$] = '{0, 1, 2, 3, 4, 6, 7, 12, 30, 97, 128, 210,
                                       251, 256, 4095};
        rst_n         = 1'b0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        src_idle_pct  = 23;
        dst_idle_pct  = 75;
        stall_request = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_numbers[i])
            send_number(corner_numbers[i]);
        for (int i = 0; i < 34; i++)
            send_number(pick_number(i));

        src_idle_pct = 75;
        dst_idle_pct <= 23;
        for (int i = 34; i < 67; i++)
            send_number(pick_number(i));

        src_idle_pct  = 0;
        dst_idle_pct  <= 0;
        stall_request <= 1'b1;
        // short numbers keep the block fast enough to back up during the hold-off
        for (int i = 0; i < 6; i++)
            send_number(number_t'($urandom_range(15, 0)));
        for (int i = 73; i < 100; i++)
            send_number(pick_number(i));
        num_ch.valid <= 1'b0;

        // let the last transaction reach the checker before polling it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #300_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
